>>> src/sbsh_pkg.sv
// ----------------------------------------------------------------------------
// sbsh_pkg: shared types and constants for the sha-256 byte stream hasher
// transfer payload structs, sequencer states, round constants, hash functions
// ----------------------------------------------------------------------------
package sbsh_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
        logic        length_error;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_OUT
    } state_t;

    localparam logic [7:0]  PAD_BYTE  = 8'h80;
    localparam logic [5:0]  LEN_START = 6'd56;
    localparam logic [60:0] TOTAL_MAX = {61{1'b1}};

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        logic [31:0] v;
        case (i)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            3'd7: v = 32'h5be0cd19;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

>>> src/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher: byte-serial sha-256 with padding and digest out
// packs bytes into 64-byte blocks, compresses one round per cycle, pads at
// end of message and returns eight digest words
// ----------------------------------------------------------------------------
//  channel  | signals                    | payload
//  ---------+----------------------------+---------------------------------
//  item     | item_valid / item_ready    | item_t: byte, present, end flag
//  digest   | digest_valid / digest_ready| result_t: word, index, last, err
//
//  the 64th byte of a block starts 64 rounds through one shared round unit,
//  then the chaining add
//  end of message: pad bytes (up to 64 + 8) go in at one per cycle while no
//  compression runs, with one or two compressions, then eight digest transfers
//  item_ready is low after a block-filling byte until its chaining add is done,
//  and from an end-of-message transfer until the last digest word is drained
//  reset: rst_n async low, chaining value back to the initial hash
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher
    import sbsh_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    digest_valid,
    input  logic    digest_ready,
    output result_t digest
);

    state_t        state_reg,   state_next;
    logic [31:0]   chain_reg   [8];
    logic [31:0]   chain_next  [8];
    logic [31:0]   work_reg    [8];
    logic [31:0]   work_next   [8];
    logic [31:0]   sched_reg   [16];
    logic [31:0]   sched_next  [16];
    logic [5:0]    fill_reg,    fill_next;
    logic [60:0]   total_reg,   total_next;
    logic          ovf_reg,     ovf_next;
    logic [5:0]    rnd_reg,     rnd_next;
    logic          pad_act_reg, pad_act_next;   // end of message seen
    logic          pad80_reg,   pad80_next;     // 0x80 byte already placed
    logic [3:0]    len_idx_reg, len_idx_next;   // length bytes placed, 0..8
    logic [2:0]    out_idx_reg, out_idx_next;

    // byte path shared by message and pad bytes
    logic          put_en;
    logic [7:0]    put_val;
    logic [63:0]   bit_len;
    logic [7:0]    len_byte;

    // round unit
    logic [31:0]   t1, t2, w_new;

    assign bit_len = {total_reg, 3'b000};

    always_comb
    begin
        case (len_idx_reg[2:0])
            3'd0:    len_byte = bit_len[63:56];
            3'd1:    len_byte = bit_len[55:48];
            3'd2:    len_byte = bit_len[47:40];
            3'd3:    len_byte = bit_len[39:32];
            3'd4:    len_byte = bit_len[31:24];
            3'd5:    len_byte = bit_len[23:16];
            3'd6:    len_byte = bit_len[15:8];
            3'd7:    len_byte = bit_len[7:0];
            default: len_byte = 8'h00;
        endcase
    end

    assign w_new = sched_reg[0] + small_sigma0(sched_reg[1]) + sched_reg[9]
                 + small_sigma1(sched_reg[14]);
    assign t1 = work_reg[7] + big_sigma1(work_reg[4])
              + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
              + round_k(rnd_reg) + sched_reg[0];
    assign t2 = big_sigma0(work_reg[0])
              + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                 ^ (work_reg[1] & work_reg[2]));

    assign item_ready   = (state_reg == ST_IDLE);
    assign digest_valid = (state_reg == ST_OUT);
    assign digest.digest_word  = chain_reg[out_idx_reg];
    assign digest.word_index   = out_idx_reg;
    assign digest.last_word    = (out_idx_reg == 3'd7);
    assign digest.length_error = ovf_reg;

    always_comb
    begin
        state_next   = state_reg;
        chain_next   = chain_reg;
        work_next    = work_reg;
        sched_next   = sched_reg;
        fill_next    = fill_reg;
        total_next   = total_reg;
        ovf_next     = ovf_reg;
        rnd_next     = rnd_reg;
        pad_act_next = pad_act_reg;
        pad80_next   = pad80_reg;
        len_idx_next = len_idx_reg;
        out_idx_next = out_idx_reg;
        put_en       = 1'b0;
        put_val      = 8'h00;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    put_en  = item.byte_present;
                    put_val = item.data_byte;
                    if (item.byte_present)
                    begin
                        if (total_reg == TOTAL_MAX)
                            ovf_next = 1'b1;
                        else
                            total_next = total_reg + 61'd1;
                    end
                    if (item.end_of_message)
                    begin
                        pad_act_next = 1'b1;
                        state_next   = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                put_en = 1'b1;
                if (!pad80_reg)
                begin
                    put_val    = PAD_BYTE;
                    pad80_next = 1'b1;
                end
                else if (len_idx_reg == 4'd0 && fill_reg != LEN_START)
                    put_val = 8'h00;
                else
                begin
                    put_val      = len_byte;
                    len_idx_next = len_idx_reg + 4'd1;
                end
            end
            ST_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                    sched_next[i] = sched_reg[i+1];
                sched_next[15] = w_new;
                work_next[7] = work_reg[6];
                work_next[6] = work_reg[5];
                work_next[5] = work_reg[4];
                work_next[4] = work_reg[3] + t1;
                work_next[3] = work_reg[2];
                work_next[2] = work_reg[1];
                work_next[1] = work_reg[0];
                work_next[0] = t1 + t2;
                rnd_next     = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                for (int i = 0; i < 8; i++)
                    chain_next[i] = chain_reg[i] + work_reg[i];
                if (len_idx_reg == 4'd8)
                    state_next = ST_OUT;
                else if (pad_act_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                if (digest_ready)
                begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == 3'd7)
                    begin
                        for (int i = 0; i < 8; i++)
                            chain_next[i] = init_hash(3'(i));
                        fill_next    = 6'd0;
                        total_next   = '0;
                        ovf_next     = 1'b0;
                        pad_act_next = 1'b0;
                        pad80_next   = 1'b0;
                        len_idx_next = 4'd0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        // pack byte big-endian; first byte of a word clears the rest
        if (put_en)
        begin
            case (fill_reg[1:0])
                2'd0:    sched_next[fill_reg[5:2]] = {put_val, 24'h0};
                2'd1:    sched_next[fill_reg[5:2]][23:16] = put_val;
                2'd2:    sched_next[fill_reg[5:2]][15:8]  = put_val;
                2'd3:    sched_next[fill_reg[5:2]][7:0]   = put_val;
                default: sched_next[fill_reg[5:2]] = sched_reg[fill_reg[5:2]];
            endcase
            fill_next = fill_reg + 6'd1;
            // block full: start compression
            if (fill_reg == 6'd63)
            begin
                work_next  = chain_reg;
                rnd_next   = 6'd0;
                state_next = ST_ROUND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= 6'd0;
            total_reg   <= '0;
            ovf_reg     <= 1'b0;
            rnd_reg     <= 6'd0;
            pad_act_reg <= 1'b0;
            pad80_reg   <= 1'b0;
            len_idx_reg <= 4'd0;
            out_idx_reg <= 3'd0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= init_hash(3'(i));
                work_reg[i]  <= 32'h0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            total_reg   <= total_next;
            ovf_reg     <= ovf_next;
            rnd_reg     <= rnd_next;
            pad_act_reg <= pad_act_next;
            pad80_reg   <= pad80_next;
            len_idx_reg <= len_idx_next;
            out_idx_reg <= out_idx_next;
            chain_reg   <= chain_next;
            work_reg    <= work_next;
        end
    end

    // message schedule window, no reset
    always_ff @(posedge clk)
    begin
        sched_reg <= sched_next;
    end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sha-256 byte stream hasher
// drives byte and end-of-message transfers from a queue, predicts each digest
// with an independent sha-256 model and checks every digest word in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import sbsh_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    digest_valid;
    logic    digest_ready;
    result_t digest;

    sha256_byte_stream_hasher u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest)
    );

    // predictor state: chaining value, block buffer, fill and length count
    logic [31:0] chain_h [8];
    logic [31:0] msg_w [16];
    logic [5:0]  fill_cnt;
    logic [60:0] len_bytes;
    logic        len_ovf;

    item_t   pending_items [$];
    result_t expected_words [$];

    int  errors;
    int  cycle_cnt;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_off_cycles;
    int  msgs_closed;
    int  words_checked;

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of msg_w into chain_h
    task automatic compress_block();
        logic [31:0] v [8];
        logic [31:0] sw [64];
        logic [31:0] t1, t2;
        for (int i = 0; i < 8; i++) v[i] = chain_h[i];
        for (int r = 0; r < 64; r++)
        begin
            if (r < 16) sw[r] = msg_w[r];
            else sw[r] = sw[r-16] + (ror(sw[r-15], 7) ^ ror(sw[r-15], 18) ^ (sw[r-15] >> 3))
                       + sw[r-7] + (ror(sw[r-2], 17) ^ ror(sw[r-2], 19) ^ (sw[r-2] >> 10));
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[r] + sw[r];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        if (fill_cnt[1:0] == 2'd0) msg_w[fill_cnt[5:2]] = '0;
        msg_w[fill_cnt[5:2]][8*(3-fill_cnt[1:0]) +: 8] = b;
        fill_cnt = fill_cnt + 6'd1;
        if (fill_cnt == 6'd0) compress_block();
    endtask

    task automatic predictor_reset();
        for (int i = 0; i < 8; i++) chain_h[i] = H_INIT[i];
        fill_cnt  = '0;
        len_bytes = '0;
        len_ovf   = 1'b0;
    endtask

    // applies one accepted item and queues the digest words it produces
    task automatic predict_digest(input item_t it);
        logic [63:0] bit_len;
        result_t r;
        if (it.byte_present)
        begin
            absorb_byte(it.data_byte);
            if (len_bytes == TOTAL_MAX) len_ovf = 1'b1;
            else len_bytes = len_bytes + 61'd1;
        end
        if (it.end_of_message)
        begin
            bit_len = {len_bytes, 3'b000};
            absorb_byte(PAD_BYTE);
            while (fill_cnt != LEN_START) absorb_byte(8'h00);
            for (int i = 7; i >= 0; i--) absorb_byte(bit_len[8*i +: 8]);
            for (int i = 0; i < 8; i++)
            begin
                r.digest_word  = chain_h[i];
                r.word_index   = 3'(i);
                r.last_word    = (i == 7);
                r.length_error = len_ovf;
                expected_words.insert(expected_words.size(), r);
            end
            msgs_closed++;
            predictor_reset();
        end
    endtask

    function automatic item_t mk_item(input logic [7:0] b, input bit pres, input bit eom);
        item_t it;
        it.data_byte      = b;
        it.byte_present   = pres;
        it.end_of_message = eom;
        return it;
    endfunction

    // appends one item at the tail of the pending queue
    task automatic add_item(input item_t it);
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic push_message(input int n_bytes, input bit eom_byte);
        for (int i = 0; i < n_bytes; i++)
        begin
            // occasional idle items inside a message
            if ($urandom_range(0, 15) == 0)
                add_item(mk_item(8'($urandom), 1'b0, 1'b0));
            add_item(mk_item(8'($urandom), 1'b1, 1'b0));
        end
        add_item(mk_item(8'($urandom), eom_byte, 1'b1));
    endtask

    always #5 clk = ~clk;

    // driver: present next queued item, hold until transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else if (!item_valid || item_ready)
        begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                item_valid <= 1'b1;
                item       <= pending_items.pop_front();
            end
            else
                item_valid <= 1'b0;
        end
    end

    // prediction runs on each accepted item transfer
    always @(posedge clk)
    begin
        if (rst_n && item_valid && item_ready) predict_digest(item);
    end

    // receiver ready, with random stalls and an optional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            digest_ready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            digest_ready    <= 1'b0;
        end
        else
            digest_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: compare each digest transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && digest_valid && digest_ready)
        begin
            if (expected_words.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected digest transfer, actual %h", $realtime, digest);
            end
            else
            begin
                result_t e;
                e = expected_words.pop_front();
                words_checked++;
                if (digest.digest_word !== e.digest_word)
                begin
                    errors++;
                    $display("%0t: digest_word expected %h actual %h",
                             $realtime, e.digest_word, digest.digest_word);
                end
                if (digest.word_index !== e.word_index)
                begin
                    errors++;
                    $display("%0t: word_index expected %0d actual %0d",
                             $realtime, e.word_index, digest.word_index);
                end
                if (digest.last_word !== e.last_word)
                begin
                    errors++;
                    $display("%0t: last_word expected %b actual %b",
                             $realtime, e.last_word, digest.last_word);
                end
                if (digest.length_error !== e.length_error)
                begin
                    errors++;
                    $display("%0t: length_error expected %b actual %b",
                             $realtime, e.length_error, digest.length_error);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("tb: timeout after %0d cycles", cycle_cnt);
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || item_valid || expected_words.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        digest_ready = 1'b0;
        errors = 0;
        cycle_cnt = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        msgs_closed = 0;
        words_checked = 0;
        predictor_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty message, idle items, lone end, byte with end,
        // 55/56/64 byte lengths around the extra-block boundary, extremes
        add_item(mk_item(8'hff, 1'b0, 1'b0));
        add_item(mk_item(8'h00, 1'b0, 1'b1));
        add_item(mk_item(8'h00, 1'b1, 1'b1));
        add_item(mk_item(8'hff, 1'b1, 1'b1));
        add_item(mk_item(8'h61, 1'b1, 1'b0));
        add_item(mk_item(8'h62, 1'b1, 1'b0));
        add_item(mk_item(8'h63, 1'b0, 1'b1));
        push_message(55, 1'b0);
        push_message(55, 1'b1);
        push_message(63, 1'b1);
        push_message(64, 1'b0);
        wait_drained();

        // random messages across idling phases; lengths mostly short
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 17 : 48) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 17 : 48) : 0;
            if (ph == 2) hold_off_cycles = 400;
            for (int m = 0; m < 2; m++)
            begin
                int n;
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 130)
                                                : $urandom_range(0, 20);
                push_message(n, 1'($urandom_range(0, 1)));
            end
            wait_drained();
        end

        repeat (300) @(posedge clk);
        // the length overflow case would need 2^61 bytes and is out of reach
        $display("tb: %0d messages closed, %0d digest words checked",
                 msgs_closed, words_checked);
        $display("tb: covered empty, boundary and random lengths with stalls");
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
